/* sv/kmcd_pkg.sv */
package kmcd_pkg;

  // Fixed field widths of the two channels.
  localparam int unsigned COL_W   = 4;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned ROW_SEL_W = 3;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned HELD_W  = 7;

  // Depth of the job queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;

  // Result kinds.
  localparam logic ITEM_KEY   = 1'b0;
  localparam logic ITEM_SWEEP = 1'b1;

  // Scan code flag for a key release.
  localparam logic [CODE_W-1:0] RELEASE_FLAG = 8'h80;

  // Largest value the held counter may reach.
  localparam logic [HELD_W-1:0] HELD_MAX = 7'h7f;

  // One column reading.
  typedef struct packed {
    logic [COL_W-1:0] column_index;
    logic [ROW_W-1:0] row_bits;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic              item_kind;
    logic [CODE_W-1:0] scan_code;
    logic [HELD_W-1:0] held_count;
    logic              rescan_wanted;
    logic              last_of_run;
  } out_item_t;

  // Work handed from the front to the back for one column reading.
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] change;
    logic [ROW_W-1:0] sense;
    logic             is_last;
    logic             rescan;
  } job_t;

  // Queue status seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* sv/kmcd_front.sv */
module kmcd_front import kmcd_pkg::*; #(
  parameter int unsigned ROW_COUNT    = 8,
  parameter int unsigned COLUMN_COUNT = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  in_item_t      in_data,
  input  queue_status_t q_status,
  output logic          in_full,
  output logic          q_push,
  output job_t          q_job
);

  localparam int unsigned COL_IDX_W = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
  localparam logic [ROW_W:0] ROW_MASK_WIDE = (9'd1 << ROW_COUNT) - 9'd1;
  localparam logic [ROW_W-1:0] ROW_MASK = ROW_MASK_WIDE[ROW_W-1:0];
  localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(COLUMN_COUNT);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMN_COUNT - 1);

  logic [ROW_W-1:0]     key_r [COLUMN_COUNT];
  logic                 sweep_any_r;
  logic                 sweep_any_nxt;

  logic                 accept;
  logic                 col_ok;
  logic                 is_last;
  logic [COL_IDX_W-1:0] idx;
  logic [ROW_W-1:0]     sense;
  logic [ROW_W-1:0]     stored;
  logic [ROW_W-1:0]     change;

  // Classify the incoming column against the stored key state.
  always_comb begin
    accept  = in_push && !q_status.full;
    col_ok  = in_data.column_index < COL_LIMIT;
    is_last = in_data.column_index == COL_LAST;
    idx     = in_data.column_index[COL_IDX_W-1:0];
    sense   = in_data.row_bits & ROW_MASK;
    stored  = col_ok ? key_r[idx] : '0;
    change  = sense ^ stored;
  end

  // A job goes to the back only when it yields at least one result.
  always_comb begin
    in_full        = q_status.full;
    q_push         = accept && col_ok && ((change != '0) || is_last);
    q_job.column   = in_data.column_index;
    q_job.change   = change;
    q_job.sense    = sense;
    q_job.is_last  = is_last;
    q_job.rescan   = sweep_any_r || (sense != '0);
  end

  // The sweep flag collects presses and clears after the last column.
  always_comb begin
    sweep_any_nxt = sweep_any_r;
    if (accept && col_ok) begin
      if (is_last) begin
        sweep_any_nxt = 1'b0;
      end else if (sense != '0) begin
        sweep_any_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < COLUMN_COUNT; c++) begin
        key_r[c] <= '0;
      end
      sweep_any_r <= 1'b0;
    end else begin
      sweep_any_r <= sweep_any_nxt;
      if (accept && col_ok) begin
        key_r[idx] <= sense;
      end
    end
  end

endmodule

/* sv/kmcd_queue.sv */
module kmcd_queue import kmcd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  job_t          push_job,
  input  logic          pop,
  output job_t          head_job,
  output queue_status_t status
);

  localparam logic [QUEUE_PTR_W:0] COUNT_FULL = (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);

  job_t                   slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_PTR_W:0]   count_r;
  logic                   do_push;
  logic                   do_pop;

  // Status and head of the queue.
  always_comb begin
    status.full  = count_r == COUNT_FULL;
    status.empty = count_r == '0;
    do_push      = push && !status.full;
    do_pop       = pop && !status.empty;
    head_job     = slot_r[rd_ptr_r];
  end

  // Payload slots carry no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* sv/kmcd_back.sv */
module kmcd_back import kmcd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  job_t          head_job,
  input  queue_status_t q_status,
  output logic          q_pop,
  input  logic          out_pop,
  output logic          out_empty,
  output out_item_t     out_data
);

  logic                 out_valid_r;
  out_item_t            out_data_r;
  out_item_t            out_data_nxt;
  logic [ROW_W-1:0]     done_r;
  logic [ROW_W-1:0]     done_nxt;
  logic [HELD_W-1:0]    held_r;
  logic [HELD_W-1:0]    held_nxt;

  logic                 slot_free;
  logic                 step;
  logic [ROW_W-1:0]     remaining;
  logic [ROW_W-1:0]     rest;
  logic [ROW_W-1:0]     sel_bit;
  logic [ROW_SEL_W-1:0] sel_row;
  logic                 has_event;
  logic                 pressed;
  logic [HELD_W-1:0]    code;

  // Lowest changed row that has not been emitted yet.
  always_comb begin
    remaining = head_job.change & ~done_r;
    has_event = remaining != '0;
    sel_row   = '0;
    for (int r = ROW_W - 1; r >= 0; r--) begin
      if (remaining[r]) begin
        sel_row = ROW_SEL_W'(r);
      end
    end
    sel_bit = ROW_W'(1) << sel_row;
    rest    = remaining & ~sel_bit;
    pressed = head_job.sense[sel_row];
    code    = {sel_row, 4'b0000} + HELD_W'(head_job.column) + HELD_W'(1);
  end

  // One result per cycle whenever a job is waiting and the output register can take it.
  always_comb begin
    slot_free    = !out_valid_r || out_pop;
    step         = slot_free && !q_status.empty;
    held_nxt     = held_r;
    done_nxt     = done_r;
    q_pop        = 1'b0;
    out_data_nxt = out_data_r;
    if (step) begin
      if (has_event) begin
        if (pressed) begin
          held_nxt = (held_r == HELD_MAX) ? held_r : held_r + 1'b1;
        end else begin
          held_nxt = (held_r == '0) ? held_r : held_r - 1'b1;
        end
        out_data_nxt.item_kind     = ITEM_KEY;
        out_data_nxt.scan_code     = {1'b0, code} | (pressed ? '0 : RELEASE_FLAG);
        out_data_nxt.held_count    = held_nxt;
        out_data_nxt.rescan_wanted = 1'b0;
        out_data_nxt.last_of_run   = (rest == '0) && !head_job.is_last;
        if (out_data_nxt.last_of_run) begin
          q_pop    = 1'b1;
          done_nxt = '0;
        end else begin
          done_nxt = done_r | sel_bit;
        end
      end else begin
        out_data_nxt.item_kind     = ITEM_SWEEP;
        out_data_nxt.scan_code     = '0;
        out_data_nxt.held_count    = held_r;
        out_data_nxt.rescan_wanted = head_job.rescan;
        out_data_nxt.last_of_run   = 1'b1;
        q_pop                      = 1'b1;
        done_nxt                   = '0;
      end
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

  // Output payload register.
  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Control state of the back end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= '0;
      held_r      <= '0;
    end else begin
      out_valid_r <= step || (out_valid_r && !out_pop);
      done_r      <= done_nxt;
      held_r      <= held_nxt;
    end
  end

endmodule

/* sv/key_matrix_change_detector_core.sv */
// Channel  | Ports                       | Beat taken when
// ---------+-----------------------------+-------------------------
// input    | in_push, in_full, in_data   | in_push && !in_full
// result   | out_empty, out_pop, out_data| out_pop && !out_empty
//
// A column reading is classified in the cycle it is taken; one beat can be
// taken every cycle while the four-entry job queue has room.
// The back end emits one result per cycle while results are popped, and a reading
// yields 0 to 9 results: one per changed row, plus one after the last column.
// The synchronous reset clears key state, the held count and the job queue.
// A stalled result side fills the job queue and then raises in_full.
module key_matrix_change_detector_core import kmcd_pkg::*; #(
  parameter int unsigned ROW_COUNT    = 8,
  parameter int unsigned COLUMN_COUNT = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic          q_push;
  logic          q_pop;
  job_t          q_job;
  job_t          head_job;
  queue_status_t q_status;

  // Front: compares each column with the stored key state.
  kmcd_front #(
    .ROW_COUNT    (ROW_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .q_status (q_status),
    .in_full  (in_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  // Job queue between front and back.
  kmcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head_job (head_job),
    .status   (q_status)
  );

  // Back: emits key events and sweep-done items one at a time.
  kmcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

/* sv/kmcd_checker.sv */
module kmcd_checker import kmcd_pkg::*; #(
  parameter int unsigned ROW_COUNT    = 8,
  parameter int unsigned COLUMN_COUNT = 14
) (
  input logic      clk,
  input logic      rst_n,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_data
);

  localparam logic [HELD_W-1:0] KEY_TOTAL = HELD_W'(ROW_COUNT * COLUMN_COUNT);

  // Reset leaves no result waiting.
  assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result waiting after reset");

  // A waiting beat holds until it is popped.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed before pop");

  // A sweep-done item always closes its run and carries no scan code.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.item_kind == ITEM_SWEEP) |->
      (out_data.last_of_run && out_data.scan_code == '0))
    else $error("malformed sweep-done item");

  // Key events never request a rescan.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.item_kind == ITEM_KEY) |-> !out_data.rescan_wanted)
    else $error("key event with rescan request");

  // The held count never exceeds the number of keys in the matrix.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.held_count <= KEY_TOTAL))
    else $error("held count out of range");

endmodule

bind key_matrix_change_detector_core kmcd_checker #(
  .ROW_COUNT    (ROW_COUNT),
  .COLUMN_COUNT (COLUMN_COUNT)
) u_kmcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
